@@ rtl/core/lcae_pkg.sv @@
`default_nettype none

package lcae_pkg;

    // Grid geometry
    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    // Field widths
    localparam int OP_W  = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;
    localparam int GEN_W = 16;

    // Rotation counter and compare widths
    localparam int CNT_W     = $clog2(GRID_ROWS);
    localparam int CMP_W     = (CNT_W > ROW_W) ? CNT_W : ROW_W;
    localparam int COL_IDX_W = $clog2(GRID_COLS);
    localparam int COL_CMP_W = COL_W + 1;

    // Rule constants
    localparam logic [3:0] BIRTH_COUNT  = 4'd3;
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;

    typedef logic [OP_W-1:0]      opcode_t;
    typedef logic [ROW_W-1:0]     row_addr_t;
    typedef logic [COL_W-1:0]     col_addr_t;
    typedef logic [GEN_W-1:0]     gen_count_t;
    typedef logic [GRID_COLS-1:0] row_word_t;

    localparam opcode_t OP_WRITE = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_STEP  = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/lcae_channels.sv @@
`default_nettype none

interface lcae_in_if;
    logic                 valid;
    logic                 ready;
    lcae_pkg::opcode_t    opcode;
    lcae_pkg::row_addr_t  cell_row;
    lcae_pkg::col_addr_t  cell_col;
    logic                 write_alive;

    modport source (output valid, output opcode, output cell_row, output cell_col,
                    output write_alive, input ready);
    modport sink   (input valid, input opcode, input cell_row, input cell_col,
                    input write_alive, output ready);
endinterface

interface lcae_out_if;
    logic                  valid;
    logic                  ready;
    logic                  read_alive;
    lcae_pkg::gen_count_t  generation_count;

    modport source (output valid, output read_alive, output generation_count, input ready);
    modport sink   (input valid, input read_alive, input generation_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lcae_row_cell.sv @@
`default_nettype none

module lcae_row_cell
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                shift_en,
    input  wire lcae_pkg::row_word_t d,
    output lcae_pkg::row_word_t      q
);
    import lcae_pkg::*;

    row_word_t word_reg;
    row_word_t word_next;

    // Take the neighbour's row on every rotation step, hold otherwise
    always_comb
    begin
        word_next = shift_en ? d : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule

`default_nettype wire

@@ rtl/core/lcae_rule_unit.sv @@
`default_nettype none

module lcae_rule_unit
(
    input  wire lcae_pkg::row_word_t above,
    input  wire lcae_pkg::row_word_t middle,
    input  wire lcae_pkg::row_word_t below,
    input  wire logic                border_row,
    output lcae_pkg::row_word_t      next_word
);
    import lcae_pkg::*;

    // Per-column neighbour count and B3/S23 decision; edge columns stay dead
    always_comb
    begin
        logic [3:0] n;
        next_word = '0;
        for (int c = 1; c < GRID_COLS - 1; c++)
        begin
            n = 4'({3'b0, above[c-1]}) + 4'({3'b0, above[c]}) + 4'({3'b0, above[c+1]})
              + 4'({3'b0, middle[c-1]}) + 4'({3'b0, middle[c+1]})
              + 4'({3'b0, below[c-1]}) + 4'({3'b0, below[c]}) + 4'({3'b0, below[c+1]});
            if (middle[c])
            begin
                next_word[c] = (n >= SURVIVE_LOW) && (n <= SURVIVE_HIGH);
            end
            else
            begin
                next_word[c] = (n == BIRTH_COUNT);
            end
        end
        if (border_row)
        begin
            next_word = '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/life_cellular_automaton_engine_unit.sv @@
`default_nettype none

// Game of Life (B3/S23) engine over a GRID_ROWS x GRID_COLS grid with a dead
// border. The grid lives in a ring of row cells, one row word per cell. Every
// transaction (write cell, read cell, advance one generation, or the unused
// opcode) rotates the ring once through all GRID_ROWS rows, during which the row
// at the head is read, patched or replaced by its next generation and fed back
// into the tail. A transaction is accepted, its rotation follows, and the
// result is registered at the end of the rotation; no new transaction is
// taken until that rotation is done. A new transaction is taken while the
// previous result still waits at the output; the last rotation step holds
// only if the output register is still occupied. Reset clears every cell and
// the generation count at once. Writes to border or out-of-grid cells are
// dropped; reads of such cells return dead. generation_count reports the
// count after the transaction.

module life_cellular_automaton_engine_unit
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lcae_in_if.sink    in_ch,
    lcae_out_if.source out_ch
);
    import lcae_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(GRID_ROWS - 1);

    // Control state
    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] row_cnt_reg;
    logic [CNT_W-1:0] row_cnt_next;
    gen_count_t       gen_reg;
    gen_count_t       gen_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Captured transaction and working payload
    opcode_t          op_reg;
    row_addr_t        row_reg;
    col_addr_t        col_reg;
    logic             val_reg;
    row_word_t        prev_reg;
    logic             rd_reg;
    logic             out_rd_reg;
    gen_count_t       out_gen_reg;

    // Ring of row cells
    row_word_t        ring [GRID_ROWS];
    row_word_t        insert_word;
    row_word_t        rule_word;
    row_word_t        head_row;
    row_word_t        col_mask;

    logic             accept;
    logic             out_free;
    logic             shift_en;
    logic             finish;
    logic             border_row;
    logic             row_hit;
    logic             col_inside;
    logic             col_inner;
    logic             rd_now;
    logic [COL_IDX_W-1:0] col_idx;

    assign head_row = ring[0];

    genvar g;
    generate
        for (g = 0; g < GRID_ROWS; g++)
        begin : g_ring
            if (g == GRID_ROWS - 1)
            begin : g_tail
                lcae_row_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .d        (insert_word),
                    .q        (ring[g])
                );
            end
            else
            begin : g_body
                lcae_row_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .d        (ring[g+1]),
                    .q        (ring[g])
                );
            end
        end
    endgenerate

    // The row ahead of the head is already in cell one; the row behind it is
    // held in prev_reg from the previous rotation step
    lcae_rule_unit u_rule
    (
        .above      (prev_reg),
        .middle     (head_row),
        .below      (ring[1]),
        .border_row (border_row),
        .next_word  (rule_word)
    );

    // Handshake and sequencing
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign shift_en    = (state_reg == ST_RUN) && ((row_cnt_reg != LAST_ROW) || out_free);
    assign finish      = (state_reg == ST_RUN) && (row_cnt_reg == LAST_ROW) && out_free;

    // Address decode against the head of the ring
    assign border_row = (row_cnt_reg == '0) || (row_cnt_reg == LAST_ROW);
    assign row_hit    = (CMP_W'(row_cnt_reg) == CMP_W'(row_reg));
    assign col_inside = (COL_CMP_W'(col_reg) < COL_CMP_W'(GRID_COLS));
    assign col_inner  = (col_reg != '0) && (COL_CMP_W'(col_reg) < COL_CMP_W'(GRID_COLS - 1));
    assign col_idx    = col_reg[COL_IDX_W-1:0];
    assign col_mask   = GRID_COLS'(1) << col_idx;

    always_comb
    begin
        case (op_reg)
            OP_WRITE:
            begin
                if (row_hit && !border_row && col_inner)
                begin
                    insert_word = val_reg ? (head_row | col_mask) : (head_row & ~col_mask);
                end
                else
                begin
                    insert_word = head_row;
                end
            end
            OP_STEP:
            begin
                insert_word = rule_word;
            end
            default:
            begin
                insert_word = head_row;
            end
        endcase
    end

    // Read sample, bypassed so that a hit on the last row reaches the output
    assign rd_now = ((op_reg == OP_READ) && row_hit && col_inside) ? head_row[col_idx] : rd_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        gen_next       = gen_reg;
        out_valid_next = out_valid_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_RUN;
                    row_cnt_next = '0;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    row_cnt_next   = '0;
                    out_valid_next = 1'b1;
                    if (op_reg == OP_STEP)
                    begin
                        gen_next = gen_reg + GEN_W'(1);
                    end
                end
                else if (shift_en)
                begin
                    row_cnt_next = row_cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on accept, track the row behind the head, load result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_ch.opcode;
            row_reg <= in_ch.cell_row;
            col_reg <= in_ch.cell_col;
            val_reg <= in_ch.write_alive;
            rd_reg  <= 1'b0;
        end
        else if (shift_en)
        begin
            rd_reg <= rd_now;
        end

        if (shift_en)
        begin
            prev_reg <= head_row;
        end

        if (finish)
        begin
            out_rd_reg  <= rd_now;
            out_gen_reg <= gen_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.read_alive       = out_rd_reg;
    assign out_ch.generation_count = out_gen_reg;

    // Between transactions the ring is home, so its head is the top border row
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (head_row == '0))
        else $error("top border row not dead while idle");

    // A pending result always carries the current generation count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_gen_reg == gen_reg))
        else $error("pending result out of step with generation counter");

    // The rotation only ever waits on its final step
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && (row_cnt_reg != LAST_ROW)) |=> (row_cnt_reg != '0))
        else $error("rotation stalled or restarted mid-sweep");

endmodule

`default_nettype wire
